FILE: hw/rtl/wildcard_name_matcher_core_defines.svh
// Assertion macros shared by the wildcard name matcher RTL.
// No dependencies; included by the files that carry assertions.
`ifndef WILDCARD_NAME_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define WNM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define WNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/wnm_pkg.sv
// Types, character constants and helper functions of the wildcard name matcher.
// No dependencies; used by wnm_cell and wildcard_name_matcher_core.
package wnm_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_NAME   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QUEST    = 8'h3F;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic       restart;
    logic       name_step;
    logic       store;
    logic [7:0] fch;
  } cell_ctl_t;

  // Handed from one cell to the next position.
  typedef struct packed {
    logic carry;
    logic step;
  } cell_link_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/wnm_cell.sv
// One pattern position of the matcher: stored character and active bit.
// Depends on wnm_pkg; instantiated in a row by wildcard_name_matcher_core.
module wnm_cell #(
  parameter int unsigned LEN_W = 8,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LEN_W-1:0]   pat_len,
  input  wnm_pkg::cell_ctl_t ctl,
  input  wnm_pkg::cell_link_t link_in,
  output wnm_pkg::cell_link_t link_out,
  output logic               closed
);

  localparam logic [LEN_W-1:0] MY_IDX   = LEN_W'(IDX);
  localparam logic             IS_FIRST = (IDX == 0);

  logic [7:0] pch;
  logic       act;
  logic       act_next;
  logic       valid;
  logic       is_star;
  logic       hit_char;

  assign valid    = MY_IDX < pat_len;
  assign is_star  = valid && (pch == wnm_pkg::CH_STAR);
  assign hit_char = (pch == wnm_pkg::CH_QUEST) || (pch == ctl.fch);

  // The position right after an active star counts as active; runs of stars
  // are collapsed at load time, so one level of carry is enough.
  assign closed         = act | link_in.carry;
  assign link_out.carry = act & is_star;
  assign link_out.step  = closed & valid & ~is_star & hit_char;
  assign act_next       = (closed & is_star) | link_in.step;

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= IS_FIRST;
    end else if (ctl.restart) begin
      act <= IS_FIRST;
    end else if (ctl.name_step) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store && pat_len == MY_IDX) begin
      pch <= ctl.fch;
    end
  end

endmodule

FILE: hw/rtl/wildcard_name_matcher_core.sv
// Case-insensitive wildcard name matcher: a row of pattern cells, one per position.
// The verdict is written into the result register on the end-of-name transfer.
// Throughput: one input transfer per cycle of any mode; the cell row updates all
// positions in the cycle a name character is taken. Input stalls only while a verdict waits.
// Reset empties the pattern, clears the overflow flag and leaves only position zero active.
// Depends on wnm_pkg, wnm_cell and wildcard_name_matcher_core_defines.svh.
`include "wildcard_name_matcher_core_defines.svh"

module wildcard_name_matcher_core #(
  parameter int unsigned PATTERN_MAX = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic [1:0] s_axis_tuser,   // [1:0] mode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

  wnm_pkg::mode_t      mode;
  wnm_pkg::cell_ctl_t  ctl;
  wnm_pkg::cell_link_t links [PATTERN_MAX:0];
  logic [PATTERN_MAX:0] closed_vec;

  logic [LEN_W-1:0] raw_len;
  logic [LEN_W-1:0] raw_len_next;
  logic [LEN_W-1:0] pat_len;
  logic [LEN_W-1:0] pat_len_next;
  logic             overflow;
  logic             overflow_next;
  logic             last_star;
  logic             last_star_next;
  logic             act_end;
  logic             take;
  logic             ch_star;
  logic             room;
  logic             end_take;
  logic             hit;

  assign mode     = wnm_pkg::mode_t'(s_axis_tuser);
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign take     = s_axis_tvalid & s_axis_tready;
  assign ch_star  = (s_axis_tdata == wnm_pkg::CH_STAR);
  assign room     = raw_len < LEN_MAX;
  assign end_take = take && (mode == wnm_pkg::MODE_END);

  always_comb begin
    ctl.restart   = 1'b0;
    ctl.name_step = 1'b0;
    ctl.store     = 1'b0;
    ctl.fch       = wnm_pkg::fold_upper(s_axis_tdata);
    raw_len_next  = raw_len;
    pat_len_next  = pat_len;
    overflow_next = overflow;
    last_star_next = last_star;
    if (take) begin
      unique case (mode)
        wnm_pkg::MODE_CLEAR: begin
          ctl.restart    = 1'b1;
          raw_len_next   = '0;
          pat_len_next   = '0;
          overflow_next  = 1'b0;
          last_star_next = 1'b0;
        end
        wnm_pkg::MODE_APPEND: begin
          ctl.restart = 1'b1;
          if (room) begin
            raw_len_next = raw_len + LEN_W'(1);
            // A star right after a stored star adds nothing to the match.
            if (!(ch_star && last_star)) begin
              ctl.store      = 1'b1;
              pat_len_next   = pat_len + LEN_W'(1);
              last_star_next = ch_star;
            end
          end else begin
            overflow_next = 1'b1;
          end
        end
        wnm_pkg::MODE_NAME: begin
          ctl.name_step = 1'b1;
        end
        wnm_pkg::MODE_END: begin
          ctl.restart = 1'b1;
        end
        default: begin
          ctl.restart = 1'b0;
        end
      endcase
    end
  end

  assign links[0] = '0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wnm_cell #(
      .LEN_W (LEN_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .pat_len  (pat_len),
      .ctl      (ctl),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .closed   (closed_vec[i])
    );
  end

  // The position past the last character has no character of its own.
  assign closed_vec[PATTERN_MAX] = act_end | links[PATTERN_MAX].carry;
  assign hit = (pat_len == '0) | closed_vec[pat_len];

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_len   <= '0;
      pat_len   <= '0;
      overflow  <= 1'b0;
      last_star <= 1'b0;
      act_end   <= 1'b0;
    end else begin
      raw_len   <= raw_len_next;
      pat_len   <= pat_len_next;
      overflow  <= overflow_next;
      last_star <= last_star_next;
      if (ctl.restart) begin
        act_end <= 1'b0;
      end else if (ctl.name_step) begin
        act_end <= links[PATTERN_MAX].step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (end_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_take) begin
      m_axis_tdata <= {6'b0, overflow, hit};
    end
  end

  `WNM_ASSERT_NOW(a_len_order, 1'b1, pat_len <= raw_len && raw_len <= LEN_MAX,
    "collapsed pattern length exceeds raw length or capacity")
  `WNM_ASSERT_NOW(a_overflow_full, overflow, raw_len == LEN_MAX,
    "overflow flag set while the pattern still has room")
  `WNM_ASSERT_NOW(a_no_active_past_end, 1'b1, ((closed_vec >> pat_len) >> 1) == '0,
    "active position beyond the end of the pattern")
  `WNM_ASSERT_NEXT(a_verdict_issued, end_take, m_axis_tvalid,
    "end-of-name transfer produced no verdict")
  `WNM_ASSERT_NOW(a_hold_stalls_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
    "input taken while a verdict is held")

endmodule
